### rtl/twcs_pkg.sv
`timescale 1ns / 1ps

package twcs_pkg;

   localparam int SCREEN_W    = 1024;
   localparam int SCREEN_H    = 512;
   localparam int MAX_TEX_DIM = 256;
   localparam int FRAC_BITS   = 16;

   localparam int COL_W   = 10;
   localparam int ROW_W   = 10;
   localparam int RS_W    = 9;
   localparam int DIM_W   = 9;
   localparam int TEXC_W  = 8;
   localparam int LH_W    = 16;
   localparam int WFRAC_W = 16;
   localparam int TEXID_W = 2;
   localparam int FB_W    = 19;
   localparam int TEXEL_W = 16;
   localparam int POS_W   = 32;
   localparam int STEP_W  = DIM_W + FRAC_BITS;
   localparam int DVR_W   = LH_W;
   localparam int OFF_W   = 17;
   localparam int PROD_W  = OFF_W + STEP_W + 1;
   localparam int DIV_STEPS = STEP_W;
   localparam int CNT_W   = $clog2(DIV_STEPS);

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP_DIV,
      ST_MULT,
      ST_POS,
      ST_MOD_DIV,
      ST_MOD_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic div_iter;
      logic mult;
      logic mod_load;
      logic pos_sat;
      logic pos_mod;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_full;
      logic prod_neg;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] fit_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_TEX_DIM)) begin
         r = DIM_W'(MAX_TEX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### rtl/textured_wall_column_span.sv
`timescale 1ns / 1ps

// Texture-mapped wall column span generator. A start item (req_tuser = 0) loads a column
// and is followed by busy states with req_tready low (fewer if the start position is
// negative): the texture step and the wrap of the start position both run on one shared
// serial divider, one quotient bit per cycle. Step items (req_tuser = 1) then stream at
// one per cycle unless a full output is held, each giving one pixel item through a
// registered output stage; a step with no open span is taken and gives nothing.

module textured_wall_column_span (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // column[9:0], wall_frac[25:10], side[26], dir_x_positive[27], dir_y_negative[28],
   // tex_id[30:29], tex_cols[39:31], tex_rows[48:40], wall_rows[64:49],
   // row_start[73:65], row_end[83:74], zero fill above
   input  logic [twcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // framebuffer_index[18:0], texel_index[34:19], zero fill above
   output logic [twcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // texture_select[1:0]
   output logic [twcs_pkg::TEXID_W-1:0]        rsp_tuser,
   // last_pixel
   output logic                                rsp_tlast
);

   twcs_pkg::ctrl_cmd_type  cmd;
   twcs_pkg::dp_status_type status;

   twcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   twcs_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/twcs_div.sv
`timescale 1ns / 1ps

module twcs_div (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          iter,
   input  logic [twcs_pkg::STEP_W-1:0]   dividend,
   input  logic [twcs_pkg::DVR_W-1:0]    divisor,
   output logic [twcs_pkg::STEP_W-1:0]   quotient,
   output logic [twcs_pkg::DVR_W-1:0]    remainder
);

   logic [twcs_pkg::STEP_W-1:0] quo_ff, quo_in;
   logic [twcs_pkg::DVR_W-1:0]  rem_ff, rem_in;
   logic [twcs_pkg::DVR_W-1:0]  dvs_ff, dvs_in;
   logic [twcs_pkg::DVR_W:0]    trial;
   logic                        fits;

   // restoring division, one quotient bit per cycle while iter is high
   always_comb begin
      trial  = {rem_ff, quo_ff[twcs_pkg::STEP_W-1]};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (load) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (iter) begin
         quo_in = {quo_ff[twcs_pkg::STEP_W-2:0], fits};
         rem_in = fits ? twcs_pkg::DVR_W'(trial - {1'b0, dvs_ff})
                       : trial[twcs_pkg::DVR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/twcs_dp.sv
`timescale 1ns / 1ps

module twcs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  twcs_pkg::ctrl_cmd_type              cmd,
   output twcs_pkg::dp_status_type             status,
   input  logic [twcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [twcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [twcs_pkg::TEXID_W-1:0]        rsp_tuser,
   output logic                                rsp_tlast
);

   // request fields
   logic [twcs_pkg::COL_W-1:0]   in_column;
   logic [twcs_pkg::WFRAC_W-1:0] in_frac;
   logic                         in_side;
   logic                         in_dxp;
   logic                         in_dyn;
   logic [twcs_pkg::TEXID_W-1:0] in_tex_id;
   logic [twcs_pkg::DIM_W-1:0]   in_tex_w;
   logic [twcs_pkg::DIM_W-1:0]   in_tex_h;
   logic [twcs_pkg::LH_W-1:0]    in_lh;
   logic [twcs_pkg::RS_W-1:0]    in_rs;
   logic [twcs_pkg::ROW_W-1:0]   in_re;

   assign in_column = req_tdata[9:0];
   assign in_frac   = req_tdata[25:10];
   assign in_side   = req_tdata[26];
   assign in_dxp    = req_tdata[27];
   assign in_dyn    = req_tdata[28];
   assign in_tex_id = req_tdata[30:29];
   assign in_tex_w  = req_tdata[39:31];
   assign in_tex_h  = req_tdata[48:40];
   assign in_lh     = req_tdata[64:49];
   assign in_rs     = req_tdata[73:65];
   assign in_re     = req_tdata[83:74];

   // state
   logic signed [twcs_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [twcs_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [twcs_pkg::ROW_W-1:0]         cur_ff, cur_in;
   logic [twcs_pkg::ROW_W-1:0]         end_ff, end_in;
   logic [twcs_pkg::COL_W-1:0]         col_ff, col_in;
   logic [twcs_pkg::TEXC_W-1:0]        tcol_ff, tcol_in;
   logic [twcs_pkg::DIM_W-1:0]         w_ff, w_in;
   logic [twcs_pkg::DIM_W-1:0]         h_ff, h_in;
   logic [twcs_pkg::TEXID_W-1:0]       tex_ff, tex_in;
   logic                               active_ff, active_in;
   logic signed [twcs_pkg::OFF_W-1:0]  off_ff, off_in;
   logic signed [twcs_pkg::PROD_W-1:0] prod_ff, prod_in;

   // result register
   logic                               rv_ff, rv_in;
   logic [twcs_pkg::FB_W-1:0]          fb_ff, fb_in;
   logic [twcs_pkg::TEXEL_W-1:0]       texel_ff, texel_in;
   logic [twcs_pkg::TEXID_W-1:0]       rsel_ff, rsel_in;
   logic                               rlast_ff, rlast_in;

   // divider
   logic                               div_load;
   logic [twcs_pkg::STEP_W-1:0]        div_dividend;
   logic [twcs_pkg::DVR_W-1:0]         div_divisor;
   logic [twcs_pkg::STEP_W-1:0]        div_quo;
   logic [twcs_pkg::DVR_W-1:0]         div_rem;

   // column start
   logic [twcs_pkg::DIM_W-1:0]         w_fit, h_fit;
   logic [twcs_pkg::LH_W-1:0]          lh_fit;
   logic [twcs_pkg::WFRAC_W+twcs_pkg::DIM_W-1:0] frac_prod;
   logic [twcs_pkg::DIM_W-1:0]         tx, tx_m, tx_c;
   logic                               mirror;
   logic [twcs_pkg::ROW_W-1:0]         re_cut;
   logic                               start_active;
   logic signed [twcs_pkg::PROD_W-1:0] off_ext;
   logic [twcs_pkg::PROD_W-1:0]        step_ext;

   // pixel step
   logic                               do_pix;
   logic [twcs_pkg::FRAC_BITS-1:0]     ty_raw;
   logic [twcs_pkg::TEXC_W-1:0]        ty;
   logic [twcs_pkg::STEP_W-1:0]        period;
   logic signed [twcs_pkg::POS_W:0]    pos_sum;
   logic signed [twcs_pkg::POS_W:0]    pos_wrap;
   logic [twcs_pkg::ROW_W-1:0]         cur_nx;

   assign w_fit  = twcs_pkg::fit_dim(in_tex_w);
   assign h_fit  = twcs_pkg::fit_dim(in_tex_h);
   assign lh_fit = (in_lh == '0) ? twcs_pkg::LH_W'(1) : in_lh;

   always_comb begin
      frac_prod = (twcs_pkg::WFRAC_W + twcs_pkg::DIM_W)'(in_frac)
                * (twcs_pkg::WFRAC_W + twcs_pkg::DIM_W)'(w_fit);
      tx        = frac_prod[twcs_pkg::WFRAC_W+twcs_pkg::DIM_W-1:twcs_pkg::WFRAC_W];
      mirror    = (!in_side && in_dxp) || (in_side && in_dyn);
      tx_m      = mirror ? (w_fit - tx - twcs_pkg::DIM_W'(1)) : tx;
      tx_c      = (tx_m >= w_fit) ? (w_fit - twcs_pkg::DIM_W'(1)) : tx_m;
      re_cut    = (in_re > twcs_pkg::ROW_W'(twcs_pkg::SCREEN_H))
                ? twcs_pkg::ROW_W'(twcs_pkg::SCREEN_H) : in_re;
      start_active = ({1'b0, in_rs} < re_cut)
                  && ({1'b0, in_column} < (twcs_pkg::COL_W+1)'(twcs_pkg::SCREEN_W));
   end

   assign div_load     = cmd.load || cmd.mod_load;
   assign div_dividend = cmd.load
                       ? (twcs_pkg::STEP_W'(h_fit) << twcs_pkg::FRAC_BITS)
                       : twcs_pkg::STEP_W'(prod_ff[twcs_pkg::FRAC_BITS+twcs_pkg::STEP_W-2:
                                                   twcs_pkg::FRAC_BITS]);
   assign div_divisor  = cmd.load ? lh_fit : twcs_pkg::DVR_W'(h_ff);

   twcs_div u_div (
      .clock     (clock),
      .load      (div_load),
      .iter      (cmd.div_iter),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign off_ext  = twcs_pkg::PROD_W'(off_ff);
   assign step_ext = twcs_pkg::PROD_W'(div_quo);

   always_comb begin
      do_pix   = cmd.step && active_ff && (cur_ff < end_ff);
      ty_raw   = pos_ff[twcs_pkg::POS_W-1] ? '0
               : pos_ff[twcs_pkg::POS_W-1:twcs_pkg::POS_W-twcs_pkg::FRAC_BITS];
      ty       = (ty_raw >= twcs_pkg::FRAC_BITS'(h_ff))
               ? twcs_pkg::TEXC_W'(h_ff - twcs_pkg::DIM_W'(1))
               : twcs_pkg::TEXC_W'(ty_raw);
      period   = twcs_pkg::STEP_W'(h_ff) << twcs_pkg::FRAC_BITS;
      pos_sum  = $signed({pos_ff[twcs_pkg::POS_W-1], pos_ff})
               + $signed((twcs_pkg::POS_W+1)'(step_ff));
      pos_wrap = (pos_sum >= $signed((twcs_pkg::POS_W+1)'(period)))
               ? pos_sum - $signed((twcs_pkg::POS_W+1)'(period)) : pos_sum;
      cur_nx   = cur_ff + twcs_pkg::ROW_W'(1);
   end

   always_comb begin
      pos_in    = pos_ff;
      step_in   = step_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      col_in    = col_ff;
      tcol_in   = tcol_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      tex_in    = tex_ff;
      active_in = active_ff;
      off_in    = off_ff;
      prod_in   = prod_ff;
      rv_in     = rv_ff && !rsp_tready;
      fb_in     = fb_ff;
      texel_in  = texel_ff;
      rsel_in   = rsel_ff;
      rlast_in  = rlast_ff;

      if (cmd.load) begin
         col_in    = in_column;
         tex_in    = in_tex_id;
         w_in      = w_fit;
         h_in      = h_fit;
         tcol_in   = twcs_pkg::TEXC_W'(tx_c);
         off_in    = $signed(twcs_pkg::OFF_W'(in_rs))
                   - $signed(twcs_pkg::OFF_W'(twcs_pkg::SCREEN_H / 2))
                   + $signed(twcs_pkg::OFF_W'(lh_fit[twcs_pkg::LH_W-1:1]));
         cur_in    = twcs_pkg::ROW_W'(in_rs);
         end_in    = re_cut;
         active_in = start_active;
      end

      if (cmd.mult) begin
         step_in = div_quo;
         prod_in = off_ext * $signed(step_ext);
      end

      if (cmd.pos_sat) begin
         // below -2^31 saturates
         pos_in = (&prod_ff[twcs_pkg::PROD_W-1:twcs_pkg::POS_W-1])
                ? prod_ff[twcs_pkg::POS_W-1:0]
                : {1'b1, {(twcs_pkg::POS_W-1){1'b0}}};
      end

      if (cmd.pos_mod) begin
         pos_in = twcs_pkg::POS_W'({div_rem[twcs_pkg::TEXC_W-1:0],
                                    prod_ff[twcs_pkg::FRAC_BITS-1:0]});
      end

      if (cmd.step) begin
         if (do_pix) begin
            pos_in    = pos_wrap[twcs_pkg::POS_W-1:0];
            cur_in    = cur_nx;
            active_in = cur_nx < end_ff;
            rv_in     = 1'b1;
            fb_in     = twcs_pkg::FB_W'(cur_ff) * twcs_pkg::FB_W'(twcs_pkg::SCREEN_W)
                      + twcs_pkg::FB_W'(col_ff);
            texel_in  = twcs_pkg::TEXEL_W'(ty) * twcs_pkg::TEXEL_W'(w_ff)
                      + twcs_pkg::TEXEL_W'(tcol_ff);
            rsel_in   = tex_ff;
            rlast_in  = cur_nx == end_ff;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         step_ff   <= '0;
         cur_ff    <= '0;
         end_ff    <= '0;
         col_ff    <= '0;
         tcol_ff   <= '0;
         w_ff      <= twcs_pkg::DIM_W'(1);
         h_ff      <= twcs_pkg::DIM_W'(1);
         tex_ff    <= '0;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         step_ff   <= step_in;
         cur_ff    <= cur_in;
         end_ff    <= end_in;
         col_ff    <= col_in;
         tcol_ff   <= tcol_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         tex_ff    <= tex_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      prod_ff  <= prod_in;
      fb_ff    <= fb_in;
      texel_ff <= texel_in;
      rsel_ff  <= rsel_in;
      rlast_ff <= rlast_in;
   end

   assign status.out_full = rv_ff;
   assign status.prod_neg = prod_ff[twcs_pkg::PROD_W-1];

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = twcs_pkg::RSP_DATA_W'({texel_ff, fb_ff});
   assign rsp_tuser  = rsel_ff;
   assign rsp_tlast  = rlast_ff;

   a_span_rows: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> cur_ff < end_ff)
      else $error("active span without rows left");

   a_end_on_screen: assert property (@(posedge clock) disable iff (reset)
      end_ff <= twcs_pkg::ROW_W'(twcs_pkg::SCREEN_H))
      else $error("end row past screen");

   a_tcol_range: assert property (@(posedge clock) disable iff (reset)
      twcs_pkg::DIM_W'(tcol_ff) < w_ff)
      else $error("texture column out of range");

   a_pix_out: assert property (@(posedge clock) disable iff (reset)
      do_pix |=> rv_ff)
      else $error("pixel item lost");

endmodule

### rtl/twcs_ctrl.sv
`timescale 1ns / 1ps

module twcs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_kind,
   input  logic                      rsp_tready,
   input  twcs_pkg::dp_status_type   status,
   output logic                      req_tready,
   output twcs_pkg::ctrl_cmd_type    cmd
);

   twcs_pkg::state_type         state_ff, state_in;
   logic [twcs_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        accept;
   logic                        cnt_last;

   assign cnt_last = cnt_ff == twcs_pkg::CNT_W'(twcs_pkg::DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         twcs_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_kind == twcs_pkg::CMD_START) begin
               state_in = twcs_pkg::ST_STEP_DIV;
            end
         end
         twcs_pkg::ST_STEP_DIV: begin
            cnt_in = cnt_ff + twcs_pkg::CNT_W'(1);
            if (cnt_last) begin
               state_in = twcs_pkg::ST_MULT;
               cnt_in   = '0;
            end
         end
         twcs_pkg::ST_MULT: begin
            state_in = twcs_pkg::ST_POS;
         end
         twcs_pkg::ST_POS: begin
            cnt_in   = '0;
            state_in = status.prod_neg ? twcs_pkg::ST_IDLE : twcs_pkg::ST_MOD_DIV;
         end
         twcs_pkg::ST_MOD_DIV: begin
            cnt_in = cnt_ff + twcs_pkg::CNT_W'(1);
            if (cnt_last) begin
               state_in = twcs_pkg::ST_MOD_WR;
               cnt_in   = '0;
            end
         end
         twcs_pkg::ST_MOD_WR: begin
            state_in = twcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = twcs_pkg::ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      accept       = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         twcs_pkg::ST_IDLE: begin
            req_tready = !status.out_full || rsp_tready;
            accept     = req_tvalid && req_tready;
            cmd.load   = accept && req_kind == twcs_pkg::CMD_START;
            cmd.step   = accept && req_kind == twcs_pkg::CMD_STEP;
         end
         twcs_pkg::ST_STEP_DIV: cmd.div_iter = 1'b1;
         twcs_pkg::ST_MULT:     cmd.mult = 1'b1;
         twcs_pkg::ST_POS: begin
            cmd.pos_sat  = status.prod_neg;
            cmd.mod_load = !status.prod_neg;
         end
         twcs_pkg::ST_MOD_DIV:  cmd.div_iter = 1'b1;
         twcs_pkg::ST_MOD_WR:   cmd.pos_mod = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twcs_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
